@@ hdl/timer_ticks_to_civil_datetime_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tick-to-date converter
// Clocked, reset-qualified implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TIMER_TICKS_TO_CIVIL_DATETIME_TOP_ASSERT_SVH
`define TIMER_TICKS_TO_CIVIL_DATETIME_TOP_ASSERT_SVH

// Same-cycle implication.
`define TTCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttcd check failed");

// Next-cycle implication.
`define TTCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttcd check failed");

`endif

@@ hdl/ttcd_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcd_pkg
// Shared types, constants and the month length table of the converter.
// ----------------------------------------------------------------------------
package ttcd_pkg;

    localparam int TicksW = 64;
    localparam int EpochW = 34;
    localparam int RateW  = 32;
    localparam int StepW  = 6;

    localparam logic [RateW-1:0] SecsPerDay    = 32'd86400;
    localparam logic [RateW-1:0] DaysPerCycle  = 32'd146097;
    localparam logic [RateW-1:0] SecsPerHour   = 32'd3600;
    localparam logic [RateW-1:0] SecsPerMinute = 32'd60;
    localparam logic [RateW-1:0] RateReset     = 32'd10000000;
    localparam logic [16:0]      EpochYear     = 17'd1970;
    localparam logic [16:0]      YearsPerCycle = 17'd400;
    localparam logic [16:0]      MaxYear       = 17'd65535;
    localparam logic [7:0]       MaxCycles     = 8'd158;

    typedef enum logic [0:0] {
        CFG_BOOT_EPOCH = 1'b0,
        CFG_TICK_RATE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_TICK,
        ST_ADD,
        ST_DIV_DAY,
        ST_DIV_CYC,
        ST_YEAR,
        ST_MONTH,
        ST_DIV_HOUR,
        ST_DIV_MIN,
        ST_DONE
    } t_state;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/timer_ticks_to_civil_datetime_top.sv @@
// ----------------------------------------------------------------------------
// Timer tick count to civil UTC date and time
// Divides a 64-bit tick count by the tick rate, adds the boot epoch and splits
// the Unix seconds into Gregorian date and time of day, one word at a time.
// ----------------------------------------------------------------------------
// The five divisions use one shared restoring divider (one quotient bit a cycle). An
// overflowing epoch sum ends the word after the addition; in-range words go on through the
// day and cycle divisions, a year walk, a month walk and the hour and minute divisions.
// One word at a time; busy stays high through the strobe cycle and the next word is taken
// in the cycle after the strobe. The receiver cannot stall. Synchronous active-low reset
// returns to idle, epoch 0 and 10 MHz tick rate.
// ----------------------------------------------------------------------------
module timer_ticks_to_civil_datetime_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [ttcd_pkg::EpochW-1:0] i_cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [ttcd_pkg::TicksW-1:0] i_timer_ticks,
    output logic                        o_valid,
    output logic [15:0]                 o_year,
    output logic [3:0]                  o_month,
    output logic [4:0]                  o_day,
    output logic [4:0]                  o_hour,
    output logic [5:0]                  o_minute,
    output logic [5:0]                  o_second,
    output logic                        o_out_of_range
);
    import ttcd_pkg::*;

    // Configuration registers.
    logic [EpochW-1:0] r_epoch;
    logic [RateW-1:0]  r_rate;

    // Control state.
    t_state            r_state, n_state;
    logic [StepW-1:0]  r_cnt;

    // Shared divider: r_quo holds the dividend and collects quotient bits as it
    // shifts left, r_rem the partial remainder, r_div the divisor.
    logic [TicksW-1:0] r_quo;
    logic [RateW-1:0]  r_rem;
    logic [RateW-1:0]  r_div;

    // Calendar state.
    logic [16:0]       r_tod;
    logic [17:0]       r_days;
    logic [16:0]       r_year;
    logic [1:0]        r_y4;
    logic [6:0]        r_y100;
    logic [8:0]        r_y400;
    logic [3:0]        r_month;
    logic [4:0]        r_hour;
    logic [5:0]        r_min;
    logic [5:0]        r_sec;
    logic              r_ovf;

    logic [RateW:0]    trial;
    logic              q_bit;
    logic [RateW-1:0]  rem_next;
    logic              div_last;
    logic [TicksW:0]   sum;
    logic              leap;
    logic [8:0]        ylen;
    logic [4:0]        mlen;
    logic              cyc_ovf;

    // One restoring division step: bring down the next dividend bit and
    // subtract the divisor when it fits.
    always_comb begin
        trial    = {r_rem, r_quo[TicksW-1]};
        q_bit    = (trial >= {1'b0, r_div});
        rem_next = q_bit ? RateW'(trial - {1'b0, r_div}) : trial[RateW-1:0];
        div_last = (r_cnt == {StepW{1'b1}});
        sum      = {1'b0, r_quo} + {{(TicksW-EpochW+1){1'b0}}, r_epoch};
        leap     = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
        ylen     = leap ? 9'd366 : 9'd365;
        mlen     = month_len(r_month, leap);
        // The cycle count is the quotient as it stands after the final step.
        cyc_ovf  = (|r_quo[TicksW-2:7]) || ({r_quo[6:0], q_bit} > MaxCycles);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= '0;
            r_rate  <= RateReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BOOT_EPOCH: r_epoch <= i_cfg_data;
                CFG_TICK_RATE:  r_rate  <= i_cfg_data[RateW-1:0];
                default:        r_rate  <= r_rate;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (start) n_state = ST_DIV_TICK;
            ST_DIV_TICK: if (div_last) n_state = ST_ADD;
            ST_ADD:      n_state = sum[TicksW] ? ST_DONE : ST_DIV_DAY;
            ST_DIV_DAY:  if (div_last) n_state = ST_DIV_CYC;
            ST_DIV_CYC: begin
                if (div_last) n_state = cyc_ovf ? ST_DONE : ST_YEAR;
            end
            ST_YEAR: begin
                if ({9'd0, r_days} < {18'd0, ylen}) begin
                    n_state = (r_year > MaxYear) ? ST_DONE : ST_MONTH;
                end
            end
            ST_MONTH:    if (r_days < {13'd0, mlen}) n_state = ST_DIV_HOUR;
            ST_DIV_HOUR: if (div_last) n_state = ST_DIV_MIN;
            ST_DIV_MIN:  if (div_last) n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state) inside
                ST_DIV_TICK, ST_DIV_DAY, ST_DIV_CYC, ST_DIV_HOUR, ST_DIV_MIN: begin
                    r_cnt <= r_cnt + StepW'(1);
                end
                default: r_cnt <= '0;
            endcase
            if (r_state == ST_IDLE && start) begin
                r_ovf <= 1'b0;
            end else if (r_state == ST_ADD && sum[TicksW]) begin
                r_ovf <= 1'b1;
            end else if (r_state == ST_DIV_CYC && div_last && cyc_ovf) begin
                r_ovf <= 1'b1;
            end else if (r_state == ST_YEAR && n_state == ST_DONE) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ST_IDLE: begin
                r_quo <= i_timer_ticks;
                r_rem <= '0;
                r_div <= (r_rate == '0) ? RateW'(1) : r_rate;
            end
            ST_DIV_TICK, ST_DIV_DAY, ST_DIV_CYC, ST_DIV_HOUR, ST_DIV_MIN: begin
                r_quo <= {r_quo[TicksW-2:0], q_bit};
                r_rem <= rem_next;
                if (div_last) begin
                    if (r_state == ST_DIV_DAY) begin
                        r_tod <= rem_next[16:0];
                        r_rem <= '0;
                        r_div <= DaysPerCycle;
                    end else if (r_state == ST_DIV_CYC) begin
                        r_days  <= rem_next[17:0];
                        r_year  <= EpochYear + 17'({r_quo[6:0], q_bit}) * YearsPerCycle;
                        r_y4    <= 2'd2;
                        r_y100  <= 7'd70;
                        r_y400  <= 9'd370;
                        r_month <= '0;
                    end else if (r_state == ST_DIV_HOUR) begin
                        r_hour <= {r_quo[3:0], q_bit};
                        r_quo  <= {52'd0, rem_next[11:0]};
                        r_rem  <= '0;
                        r_div  <= SecsPerMinute;
                    end else if (r_state == ST_DIV_MIN) begin
                        r_min <= {r_quo[4:0], q_bit};
                        r_sec <= rem_next[5:0];
                    end
                end
            end
            ST_ADD: begin
                r_quo <= sum[TicksW-1:0];
                r_rem <= '0;
                r_div <= SecsPerDay;
            end
            ST_YEAR: begin
                if ({9'd0, r_days} >= {18'd0, ylen}) begin
                    r_days <= r_days - {9'd0, ylen};
                    r_year <= r_year + 17'd1;
                    r_y4   <= r_y4 + 2'd1;
                    r_y100 <= (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            ST_MONTH: begin
                if (r_days >= {13'd0, mlen}) begin
                    r_days  <= r_days - {13'd0, mlen};
                    r_month <= r_month + 4'd1;
                end else begin
                    r_quo <= {47'd0, r_tod};
                    r_rem <= '0;
                    r_div <= SecsPerHour;
                end
            end
            default: r_rem <= r_rem;
        endcase
    end

    // Outputs: an out-of-range word shows the last representable instant.
    always_comb begin
        busy           = (r_state != ST_IDLE);
        o_valid        = (r_state == ST_DONE);
        o_out_of_range = r_ovf;
        if (r_ovf) begin
            o_year   = 16'd65535;
            o_month  = 4'd12;
            o_day    = 5'd31;
            o_hour   = 5'd23;
            o_minute = 6'd59;
            o_second = 6'd59;
        end else begin
            o_year   = r_year[15:0];
            o_month  = r_month + 4'd1;
            o_day    = r_days[4:0] + 5'd1;
            o_hour   = r_hour;
            o_minute = r_min;
            o_second = r_sec;
        end
    end

`include "timer_ticks_to_civil_datetime_top_assert.svh"

    // Start raises busy, each result strobes only once, and month and time stay in range.
    `TTCD_ASSERT_NXT(a_start_busy, start && !busy, busy)
    `TTCD_ASSERT_NXT(a_single_strobe, o_valid, !o_valid && !busy)
    `TTCD_ASSERT_IMP(a_month_ok, o_valid, (o_month != 4'd0) && (o_month <= 4'd12))
    `TTCD_ASSERT_IMP(a_time_ok, o_valid, (o_hour <= 5'd23) && (o_minute <= 6'd59))

endmodule
